// ===== hdl/tli_pkg.sv =====
// Shared types, constants and helpers of the table linear interpolator.
package tli_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int NPROBE     = IDX_W;
  localparam int QW         = 33;

  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RC_INTERP = 2'd0,
    RC_LOW    = 2'd1,
    RC_HIGH   = 2'd2
  } rc_t;

  typedef enum logic [2:0] {
    REG_POINTS     = 3'd0,
    REG_LOW_LIMIT  = 3'd1,
    REG_LOW_VALUE  = 3'd2,
    REG_HIGH_LIMIT = 3'd3,
    REG_HIGH_VALUE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         point_index;
    logic signed [31:0] grid_x;
    logic signed [31:0] grid_y;
    logic signed [31:0] query_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    rc_t                range_class;
    logic               divide_fault;
  } out_t;

  typedef struct packed {
    logic signed [31:0] low_limit;
    logic signed [31:0] low_value;
    logic signed [31:0] high_limit;
    logic signed [31:0] high_value;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    in_t              item;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } srch_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] q;
    logic signed [31:0] xl;
    logic signed [31:0] xh;
    logic signed [31:0] yl;
    logic signed [31:0] yh;
    logic               single;
  } fetch_t;

  function automatic logic is_load(input srch_t s);
    return s.valid && (s.item.kind == KIND_LOAD) &&
           (32'(s.item.point_index) < MAX_POINTS);
  endfunction

  function automatic logic [IDX_W-1:0] load_addr(input srch_t s);
    return IDX_W'(s.item.point_index);
  endfunction

endpackage

// ===== hdl/tli_probe.sv =====
// One binary search step: registered x table read at the midpoint, then compare.
module tli_probe (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  tli_pkg::srch_t s_in,
  output tli_pkg::srch_t s_out
);
  import tli_pkg::*;

  logic signed [31:0] mem [MAX_POINTS];
  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid;
  logic               active;
  srch_t              s_mid;
  logic [IDX_W-1:0]   mid_r;
  logic               act_r;
  logic signed [31:0] rd;
  srch_t              s_next;

  assign mid_sum = {1'b0, s_in.lo} + {1'b0, s_in.hi} + (IDX_W+1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign active  = {1'b0, s_in.hi} > ({1'b0, s_in.lo} + (IDX_W+1)'(1));

  always_ff @(posedge clk) begin
    if (adv) begin
      rd    <= mem[mid];
      mid_r <= mid;
      act_r <= active;
      if (is_load(s_in)) begin
        mem[load_addr(s_in)] <= s_in.item.grid_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_mid.valid <= 1'b0;
    end else if (adv) begin
      s_mid <= s_in;
    end
  end

  always_comb begin
    s_next = s_mid;
    if (act_r) begin
      if (rd < s_mid.item.query_value) begin
        s_next.lo = mid_r;
      end else begin
        s_next.hi = mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out.valid <= 1'b0;
    end else if (adv) begin
      s_out <= s_next;
    end
  end

endmodule

// ===== hdl/tli_fetch.sv =====
// Reads both segment end points from the x and y tables.
module tli_fetch (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  tli_pkg::srch_t  s_in,
  output tli_pkg::fetch_t f_out
);
  import tli_pkg::*;

  logic signed [31:0] xmem [MAX_POINTS];
  logic signed [31:0] ymem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_out.valid <= 1'b0;
    end else if (adv) begin
      f_out.valid <= s_in.valid && (s_in.item.kind == KIND_QUERY);
    end
    if (adv) begin
      f_out.xl     <= xmem[s_in.lo];
      f_out.xh     <= xmem[s_in.hi];
      f_out.yl     <= ymem[s_in.lo];
      f_out.yh     <= ymem[s_in.hi];
      f_out.q      <= s_in.item.query_value;
      f_out.single <= (s_in.lo == s_in.hi);
      if (is_load(s_in)) begin
        xmem[load_addr(s_in)] <= s_in.item.grid_x;
        ymem[load_addr(s_in)] <= s_in.item.grid_y;
      end
    end
  end

endmodule

// ===== hdl/tli_arith.sv =====
// Differences, product, pipelined restoring divide, saturation and result select.
module tli_arith (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  tli_pkg::cfg_t   cfg,
  input  tli_pkg::fetch_t f_in,
  output logic            res_valid,
  output tli_pkg::out_t   res
);
  import tli_pkg::*;

  typedef struct packed {
    logic               valid;
    rc_t                cls;
    logic               single;
    logic               zero_dx;
    logic               neg;
    logic signed [31:0] yl;
    logic [31:0]        mdy;
    logic [31:0]        mdq;
    logic [31:0]        mdx;
  } e1_t;

  typedef struct packed {
    logic               valid;
    rc_t                cls;
    logic               single;
    logic               zero_dx;
    logic               neg;
    logic signed [31:0] yl;
    logic [31:0]        mdx;
    logic [63:0]        prod;
  } e2_t;

  typedef struct packed {
    logic               valid;
    rc_t                cls;
    logic               single;
    logic               zero_dx;
    logic               neg;
    logic signed [31:0] yl;
    logic [31:0]        d;
    logic               ovf;
    logic [31:0]        rem;
    logic [QW-1:0]      num;
    logic [QW-1:0]      quo;
  } dv_t;

  function automatic dv_t div_step(input dv_t s);
    dv_t         n;
    logic [32:0] r2;
    n  = s;
    r2 = {s.rem, s.num[QW-1]};
    n.num = {s.num[QW-2:0], 1'b0};
    if (r2 >= {1'b0, s.d}) begin
      n.rem = 32'(r2 - {1'b0, s.d});
      n.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      n.rem = r2[31:0];
      n.quo = {s.quo[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  logic signed [32:0] dx, dy, dq;
  e1_t e1;
  e2_t e2;
  dv_t dv [QW+1];
  logic [QW:0]        qv;
  logic signed [34:0] sum;
  logic signed [31:0] sat;
  out_t               res_next;

  assign dx = {f_in.xh[31], f_in.xh} - {f_in.xl[31], f_in.xl};
  assign dy = {f_in.yh[31], f_in.yh} - {f_in.yl[31], f_in.yl};
  assign dq = {f_in.q[31], f_in.q} - {f_in.xl[31], f_in.xl};

  // Stage one: classify against the limits and form magnitudes and the sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      e1.valid <= 1'b0;
    end else if (adv) begin
      e1.valid <= f_in.valid;
    end
    if (adv) begin
      if (f_in.q < cfg.low_limit) begin
        e1.cls <= RC_LOW;
      end else if (f_in.q > cfg.high_limit) begin
        e1.cls <= RC_HIGH;
      end else begin
        e1.cls <= RC_INTERP;
      end
      e1.single  <= f_in.single;
      e1.zero_dx <= (dx == '0);
      e1.neg     <= dy[32] ^ dq[32] ^ dx[32];
      e1.yl      <= f_in.yl;
      e1.mdy     <= dy[32] ? 32'(-dy) : dy[31:0];
      e1.mdq     <= dq[32] ? 32'(-dq) : dq[31:0];
      e1.mdx     <= dx[32] ? 32'(-dx) : dx[31:0];
    end
  end

  // Stage two: one 32 by 32 product.
  always_ff @(posedge clk) begin
    if (rst) begin
      e2.valid <= 1'b0;
    end else if (adv) begin
      e2.valid <= e1.valid;
    end
    if (adv) begin
      e2.cls     <= e1.cls;
      e2.single  <= e1.single;
      e2.zero_dx <= e1.zero_dx;
      e2.neg     <= e1.neg;
      e2.yl      <= e1.yl;
      e2.mdx     <= e1.mdx;
      e2.prod    <= e1.mdy * e1.mdq;
    end
  end

  // Stage three: a quotient of 2^33 or more saturates any sum, so it is only flagged.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (adv) begin
      dv[0].valid <= e2.valid;
    end
    if (adv) begin
      dv[0].cls     <= e2.cls;
      dv[0].single  <= e2.single;
      dv[0].zero_dx <= e2.zero_dx;
      dv[0].neg     <= e2.neg;
      dv[0].yl      <= e2.yl;
      dv[0].d       <= e2.mdx;
      dv[0].ovf     <= ({1'b0, e2.prod[63:QW]} >= e2.mdx);
      dv[0].rem     <= ({1'b0, e2.prod[63:QW]} >= e2.mdx) ? '0 : {1'b0, e2.prod[63:QW]};
      dv[0].num     <= e2.prod[QW-1:0];
      dv[0].quo     <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= div_step(dv[k]);
      end
    end
  end

  assign qv  = dv[QW].ovf ? {1'b1, {QW{1'b0}}} : {1'b0, dv[QW].quo};
  assign sum = dv[QW].neg ? (35'(dv[QW].yl) - $signed({1'b0, qv}))
                          : (35'(dv[QW].yl) + $signed({1'b0, qv}));

  always_comb begin
    if (sum > 35'sh0_7FFF_FFFF) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    res_next.range_class  = dv[QW].cls;
    res_next.divide_fault = 1'b0;
    unique case (dv[QW].cls)
      RC_LOW:  res_next.result_value = cfg.low_value;
      RC_HIGH: res_next.result_value = cfg.high_value;
      default: begin
        if (dv[QW].single) begin
          res_next.result_value = dv[QW].yl;
        end else if (dv[QW].zero_dx) begin
          res_next.result_value = dv[QW].yl;
          res_next.divide_fault = 1'b1;
        end else begin
          res_next.result_value = sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dv[QW].valid;
    end
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/table_linear_interpolator.sv =====
// Top level of the table linear interpolator pipeline.
// Usage: items arrive on item_valid/item_stall/item. A load item (kind 0)
// writes one grid point; a query item (kind 1) yields exactly one result
// transaction on result_valid/result_stall/result. Loads yield nothing.
// The grid is searched in eight probe stages, each holding its own
// copy of the x table, then both segment ends are fetched, and the
// interpolation runs through a subtract stage, one 32 by 32 multiply stage,
// a range check and a 33-stage restoring divider, one quotient bit a stage.
// A new item is taken in every cycle in which the pipeline is not held, so
// throughput is one transaction per clock while the pipeline moves.
// Loads travel down the same pipeline and update each table copy as they
// pass, so every query sees exactly the loads that came before it.
// When the receiver stalls a waiting result, the whole pipeline holds, and
// item_stall is raised in the same cycle; nothing is lost or repeated.
// Configuration writes (cfg_write, cfg_index, cfg_data) are taken at once
// and must only be made while no transaction is in flight.
// Synchronous reset empties the pipeline and restores the registers: two
// points in use and all limits and values zero. Table contents are not
// cleared, and a query must only span entries that have been loaded.
module table_linear_interpolator (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  tli_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output tli_pkg::out_t result,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import tli_pkg::*;

  logic [8:0]     points_in_use;
  cfg_t           cfg;
  logic           adv;
  logic [IDX_W:0] n_eff;
  srch_t          s [NPROBE+1];
  fetch_t         f;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use  <= 9'd2;
      cfg.low_limit  <= '0;
      cfg.low_value  <= '0;
      cfg.high_limit <= '0;
      cfg.high_value <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POINTS:     points_in_use  <= cfg_data[8:0];
        REG_LOW_LIMIT:  cfg.low_limit  <= cfg_data;
        REG_LOW_VALUE:  cfg.low_value  <= cfg_data;
        REG_HIGH_LIMIT: cfg.high_limit <= cfg_data;
        REG_HIGH_VALUE: cfg.high_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero points behaves as one, and counts past the table as a full table.
  always_comb begin
    if (points_in_use == '0) begin
      n_eff = (IDX_W+1)'(1);
    end else if (32'(points_in_use) > MAX_POINTS) begin
      n_eff = (IDX_W+1)'(MAX_POINTS);
    end else begin
      n_eff = (IDX_W+1)'(points_in_use);
    end
  end

  // Entry register: the search interval starts as the whole grid in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      s[0].valid <= 1'b0;
    end else if (adv) begin
      s[0].valid <= item_valid;
    end
    if (adv) begin
      s[0].item <= item;
      s[0].lo   <= '0;
      s[0].hi   <= IDX_W'(n_eff - (IDX_W+1)'(1));
    end
  end

  for (genvar k = 0; k < NPROBE; k++) begin : g_probe
    tli_probe u_probe (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .s_in  (s[k]),
      .s_out (s[k+1])
    );
  end

  tli_fetch u_fetch (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .s_in  (s[NPROBE]),
    .f_out (f)
  );

  tli_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .f_in      (f),
    .res_valid (result_valid),
    .res       (result)
  );

endmodule

// ===== hdl/tli_checker.sv =====
// Port-level checks of the table linear interpolator, bound to the top level.
module tli_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_stall,
  input logic          result_valid,
  input logic          result_stall,
  input tli_pkg::out_t result
);
  import tli_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or vanished");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("input stall does not follow the output register");

  a_class: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.range_class == RC_INTERP ||
                      result.range_class == RC_LOW ||
                      result.range_class == RC_HIGH))
    else $error("range class out of range");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_class != RC_INTERP |-> !result.divide_fault)
    else $error("clamped result flagged a divide fault");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== test/table_linear_interpolator_tb.sv =====
// Testbench for the table linear interpolator: directed table, then random traffic.
module table_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tli_pkg::*;

  localparam int PIPE_LATENCY      = 55;
  localparam int QUERIES_PER_PHASE = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_t         item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_t        result;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  table_linear_interpolator dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's grid and registers. The predictor reads the
  // grid only over entries the stimulus has loaded.
  logic signed [31:0] grid_x_mem [MAX_POINTS];
  logic signed [31:0] grid_y_mem [MAX_POINTS];
  logic [8:0]         n_points;
  logic signed [31:0] lo_lim, lo_val, hi_lim, hi_val;

  out_t expected_results [$];
  int   mismatch_count = 0;
  int   loaded_count = 0;   // entries 0..loaded_count-1 have been written

  // Computes the result of one query against the shadow grid and registers.
  function automatic out_t interpolate_query(logic signed [31:0] q);
    out_t r;
    int lo, hi, mid, n;
    logic signed [63:0] dx, dy, dq;
    logic [127:0] prod;
    logic [127:0] quot;
    logic [63:0] mdx;
    logic signed [63:0] qcap, sum;
    logic neg;
    r = '0;
    if (q < lo_lim) begin
      r.result_value = lo_val;
      r.range_class = RC_LOW;
      return r;
    end
    if (q > hi_lim) begin
      r.result_value = hi_val;
      r.range_class = RC_HIGH;
      return r;
    end
    r.range_class = RC_INTERP;
    n = (n_points == 0) ? 1 : (n_points > MAX_POINTS) ? MAX_POINTS : int'(n_points);
    lo = 0;
    hi = n - 1;
    while (hi > lo + 1) begin
      mid = (lo + hi + 1) / 2;
      if (grid_x_mem[mid] < q) lo = mid;
      else hi = mid;
    end
    if (lo == hi) begin
      r.result_value = grid_y_mem[lo];
      return r;
    end
    dx = 64'(grid_x_mem[hi]) - 64'(grid_x_mem[lo]);
    if (dx == 0) begin
      r.result_value = grid_y_mem[lo];
      r.divide_fault = 1'b1;
      return r;
    end
    dy = 64'(grid_y_mem[hi]) - 64'(grid_y_mem[lo]);
    dq = 64'(q) - 64'(grid_x_mem[lo]);
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    mdx = (dx < 0) ? 64'(-dx) : 64'(dx);
    prod = 128'((dy < 0) ? -dy : dy) * 128'((dq < 0) ? -dq : dq);
    quot = prod / 128'(mdx);
    // Quotients beyond 2^40 all saturate the same way, so they are capped.
    qcap = (quot > (128'd1 << 40)) ? (64'sd1 <<< 40) : signed'(64'(quot));
    sum = neg ? 64'(grid_y_mem[lo]) - qcap : 64'(grid_y_mem[lo]) + qcap;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.result_value = 32'(sum);
    return r;
  endfunction

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result transaction: %p", result);
      end else begin
        out_t e;
        e = expected_results.pop_front();
        if (result.result_value !== e.result_value || result.range_class !== e.range_class
            || result.divide_fault !== e.divide_fault) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected value %0d class %0d fault %0b, got %0d %0d %0b",
                     e.result_value, e.range_class, e.divide_fault,
                     result.result_value, result.range_class, result.divide_fault);
        end
      end
    end
  end

  // Random receiver stalls: mostly short, sometimes long, with quiet stretches.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (result_stall) result_stall <= (r < 60);
    else if ((($time / 5000) % 3) == 0) result_stall <= 1'b0;
    else result_stall <= (r < 15);
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Sends one transaction; the expectation is recorded at acceptance.
  // Valid stays high after acceptance so that a following transaction can go
  // back to back; a gap, a drain or a register write lowers it.
  task automatic send_item(in_t it, bit has_golden, out_t golden);
    int g;
    out_t pred;
    g = gap_length();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (it.kind == KIND_LOAD) begin
      grid_x_mem[it.point_index] = it.grid_x;
      grid_y_mem[it.point_index] = it.grid_y;
    end else begin
      pred = interpolate_query(it.query_value);
      if (has_golden && pred !== golden) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Directed row disagrees with predictor: %p vs %p", golden, pred);
      end
      expected_results.push_back(pred);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    item_valid <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_POINTS:     n_points = val[8:0];
      REG_LOW_LIMIT:  lo_lim = val;
      REG_LOW_VALUE:  lo_val = val;
      REG_HIGH_LIMIT: hi_lim = val;
      REG_HIGH_VALUE: hi_val = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits for the pipeline to drain before touching the registers.
  task automatic drain();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  function automatic in_t load_item(int idx, logic [31:0] x, logic [31:0] y);
    in_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.point_index = idx[7:0];
    it.grid_x = x;
    it.grid_y = y;
    it.query_value = $urandom();
    return it;
  endfunction

  function automatic in_t query_item(logic [31:0] q);
    in_t it;
    it.kind = KIND_QUERY;
    it.point_index = $urandom();
    it.grid_x = $urandom();
    it.grid_y = $urandom();
    it.query_value = q;
    return it;
  endfunction

  // Directed rows: a query with an optional typed-in result.
  typedef struct {
    logic [31:0] q;
    bit          has_golden;
    out_t        golden;
  } directed_row_t;

  directed_row_t directed_rows [$];

  function automatic out_t mk(logic [31:0] v, rc_t c, logic f);
    out_t o;
    o.result_value = v;
    o.range_class = c;
    o.divide_fault = f;
    return o;
  endfunction

  // Fills a fresh grid of n points; sorted or not, with occasional repeated x.
  task automatic load_grid(int n, bit sorted);
    logic signed [31:0] x;
    x = sorted ? -32'sd2000000 - $urandom_range(0, 1 << 20) : 0;
    for (int i = 0; i < n; i++) begin
      if (sorted) x = x + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << 18));
      else x = $urandom();
      send_item(load_item(i, x, $urandom()), 0, '0);
    end
    if (n > loaded_count) loaded_count = n;
  endtask

  // Picks a query near the grid, at its points, or anywhere.
  function automatic logic [31:0] pick_query();
    int r, k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, ((n_points == 0) ? 1 :
                           (n_points > MAX_POINTS) ? MAX_POINTS : n_points) - 1);
    if (r < 3) return grid_x_mem[k];
    if (r < 7) return 32'(grid_x_mem[k] + $signed($urandom_range(0, 1 << 19)) - (1 << 18));
    return $urandom();
  endfunction

  initial begin
    out_t none;
    none = '0;
    n_points = 9'd2;
    lo_lim = 0;
    lo_val = 0;
    hi_lim = 0;
    hi_val = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset both limits are zero: only a query of exactly zero interpolates.
    send_item(load_item(0, 32'h0000_0000, 32'h0001_0000), 0, none);
    send_item(load_item(1, 32'h0001_0000, 32'h0003_0000), 0, none);
    send_item(load_item(255, 32'h7fff_ffff, 32'h8000_0000), 0, none);
    loaded_count = 2;
    directed_rows.push_back('{32'h8000_0000, 1, mk(0, RC_LOW, 0)});
    directed_rows.push_back('{32'h7fff_ffff, 1, mk(0, RC_HIGH, 0)});
    directed_rows.push_back('{32'h0000_0000, 1, mk(32'h0001_0000, RC_INTERP, 0)});
    foreach (directed_rows[i])
      send_item(query_item(directed_rows[i].q), directed_rows[i].has_golden,
                directed_rows[i].golden);
    directed_rows.delete();
    drain();

    // Widest limits: extrapolation both ways, saturation, exact points.
    write_reg(REG_LOW_LIMIT, 32'h8000_0000);
    write_reg(REG_HIGH_LIMIT, 32'h7fff_ffff);
    write_reg(REG_LOW_VALUE, 32'h7fff_ffff);
    write_reg(REG_HIGH_VALUE, 32'h8000_0000);
    directed_rows.push_back('{32'h0000_8000, 1, mk(32'h0002_0000, RC_INTERP, 0)});
    directed_rows.push_back('{32'h0001_0000, 1, mk(32'h0003_0000, RC_INTERP, 0)});
    directed_rows.push_back('{32'h7fff_ffff, 1, mk(32'h7fff_ffff, RC_INTERP, 0)});
    directed_rows.push_back('{32'h8000_0000, 1, mk(32'h8000_0000, RC_INTERP, 0)});
    directed_rows.push_back('{32'hffff_0000, 0, none});
    foreach (directed_rows[i])
      send_item(query_item(directed_rows[i].q), directed_rows[i].has_golden,
                directed_rows[i].golden);
    directed_rows.delete();
    // Zero x span: equal x on both ends returns the lower y with the fault flag.
    send_item(load_item(1, 32'h0000_0000, 32'h0005_0000), 0, none);
    send_item(query_item(32'h0000_0000), 1, mk(32'h0001_0000, RC_INTERP, 1));
    drain();

    // Single point, and zero points acting as one.
    write_reg(REG_POINTS, 9'd1);
    send_item(query_item(32'h1234_5678), 1, mk(32'h0001_0000, RC_INTERP, 0));
    drain();
    write_reg(REG_POINTS, 9'd0);
    send_item(query_item(32'h8000_0000), 1, mk(32'h0001_0000, RC_INTERP, 0));
    drain();

    // Crossed limits: above both goes high, below low_limit goes low first.
    write_reg(REG_LOW_LIMIT, 32'h0001_0000);
    write_reg(REG_HIGH_LIMIT, 32'hffff_0000);
    write_reg(REG_LOW_VALUE, 32'h0000_1111);
    write_reg(REG_HIGH_VALUE, 32'h0000_2222);
    send_item(query_item(32'h0002_0000), 1, mk(32'h0000_2222, RC_HIGH, 0));
    send_item(query_item(32'h0000_0000), 1, mk(32'h0000_1111, RC_LOW, 0));
    // Loads past the end of the table are dropped; the index field only
    // reaches 255, so every index is a legal entry here.
    send_item(load_item(200, $urandom(), $urandom()), 0, none);
    drain();

    // Full grid of 256 points, then points_in_use above the table size.
    load_grid(MAX_POINTS, 1);
    drain();
    write_reg(REG_LOW_LIMIT, 32'h8000_0000);
    write_reg(REG_HIGH_LIMIT, 32'h7fff_ffff);
    write_reg(REG_POINTS, 9'd256);
    for (int i = 0; i < 6; i++) send_item(query_item(pick_query()), 0, none);
    drain();
    write_reg(REG_POINTS, 9'd511);
    for (int i = 0; i < 6; i++) send_item(query_item(pick_query()), 0, none);
    drain();

    // Random phases: mostly small grids with fresh settings.
    for (int phase = 0; phase < 24; phase++) begin
      int n, r;
      r = $urandom_range(0, 9);
      n = (r < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      write_reg(REG_POINTS, 9'(n));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_LOW_LIMIT, $urandom());
        write_reg(REG_HIGH_LIMIT, $urandom());
      end else begin
        write_reg(REG_LOW_LIMIT, 32'h8000_0000 + $urandom_range(0, 1 << 24));
        write_reg(REG_HIGH_LIMIT, 32'h7fff_ffff - $urandom_range(0, 1 << 24));
      end
      write_reg(REG_LOW_VALUE, $urandom());
      write_reg(REG_HIGH_VALUE, $urandom());
      load_grid(n, $urandom_range(0, 5) != 0);
      for (int i = 0; i < QUERIES_PER_PHASE; i++) begin
        // Some reloads mixed in, always within the loaded range.
        if ($urandom_range(0, 7) == 0) begin
          int k;
          k = $urandom_range(0, n - 1);
          send_item(load_item(k, grid_x_mem[k] + $urandom_range(0, 3) - 1, $urandom()), 0,
                    none);
        end else begin
          send_item(query_item(pick_query()), 0, none);
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== table_linear_interpolator.f =====
hdl/tli_pkg.sv
hdl/tli_probe.sv
hdl/tli_fetch.sv
hdl/tli_arith.sv
hdl/table_linear_interpolator.sv
hdl/tli_checker.sv
test/table_linear_interpolator_tb.sv
